// ----- hdl/salru_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and default sizes for the set-associative LRU tag store.
package salru_pkg;

    localparam int SETS_DEF      = 64;
    localparam int WAYS_DEF      = 8;
    localparam int ADDR_BITS_DEF = 42;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_FILL   = 2'd2,
        OP_INVAL  = 2'd3
    } salru_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } salru_state_t;

    // Set-level summary produced by the tag compare stage.
    typedef struct packed {
        logic hit;
        logic free_found;
    } salru_match_t;

endpackage

// ----- hdl/salru_mem.sv -----
`timescale 1ns / 1ps
// Set row memory: one write port, one read port, registered read data.
module salru_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 320,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/salru_match.sv -----
`timescale 1ns / 1ps
// Tag compare across the ways of one set: hit way, lowest free way, LRU way.
module salru_match #(
    parameter int WAYS  = 8,
    parameter int TAG_W = 36,
    parameter int AGE_W = 3,
    parameter int WAY_W = 3
) (
    input  logic [WAYS*(1+AGE_W+TAG_W)-1:0] row,
    input  logic [TAG_W-1:0]                tag,
    output salru_pkg::salru_match_t         flags,
    output logic [WAY_W-1:0]                hit_way,
    output logic [WAY_W-1:0]                free_way,
    output logic [WAY_W-1:0]                victim_way
);

    import salru_pkg::*;

    localparam int ENT_W = 1 + AGE_W + TAG_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

    // Walk from the top way down so the lowest qualifying way wins.
    always_comb
    begin
        logic [ENT_W-1:0] ent;
        flags      = '0;
        hit_way    = '0;
        free_way   = '0;
        victim_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            ent = row[i*ENT_W +: ENT_W];
            if (ent[ENT_W-1] && ent[TAG_W-1:0] == tag)
            begin
                flags.hit = 1'b1;
                hit_way   = WAY_W'(i);
            end
            if (!ent[ENT_W-1])
            begin
                flags.free_found = 1'b1;
                free_way         = WAY_W'(i);
            end
            // full set: ages form a permutation, the oldest holds WAYS-1
            if (ent[TAG_W +: AGE_W] == AGE_MAX)
            begin
                victim_way = WAY_W'(i);
            end
        end
    end

endmodule

// ----- hdl/salru_row_update.sv -----
`timescale 1ns / 1ps
// Next contents of a set row: valid, recency ages and tags per operation.
module salru_row_update #(
    parameter int WAYS  = 8,
    parameter int TAG_W = 36,
    parameter int AGE_W = 3,
    parameter int WAY_W = 3
) (
    input  logic [WAYS*(1+AGE_W+TAG_W)-1:0] row,
    input  logic [TAG_W-1:0]                tag,
    input  salru_pkg::salru_op_t            op,
    input  salru_pkg::salru_match_t         flags,
    input  logic [WAY_W-1:0]                hit_way,
    input  logic [WAY_W-1:0]                free_way,
    input  logic [WAY_W-1:0]                victim_way,
    output logic [WAYS*(1+AGE_W+TAG_W)-1:0] new_row,
    output logic [TAG_W-1:0]                victim_tag
);

    import salru_pkg::*;

    localparam int ENT_W = 1 + AGE_W + TAG_W;

    logic [WAY_W-1:0] pway;
    logic [AGE_W-1:0] page;

    // Way being promoted (hit way, or the LRU way on eviction) and its age.
    always_comb
    begin
        pway       = flags.hit ? hit_way : victim_way;
        page       = '0;
        victim_tag = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == pway)
            begin
                page = row[i*ENT_W + TAG_W +: AGE_W];
            end
            if (WAY_W'(i) == victim_way)
            begin
                victim_tag = row[i*ENT_W +: TAG_W];
            end
        end
    end

    always_comb
    begin
        logic [ENT_W-1:0] ent;
        logic             v;
        logic [AGE_W-1:0] a;
        logic [TAG_W-1:0] t;
        logic             nv;
        logic [AGE_W-1:0] na;
        logic [TAG_W-1:0] nt;
        new_row = row;
        for (int i = 0; i < WAYS; i++)
        begin
            ent = row[i*ENT_W +: ENT_W];
            v   = ent[ENT_W-1];
            a   = ent[TAG_W +: AGE_W];
            t   = ent[TAG_W-1:0];
            nv  = v;
            na  = a;
            nt  = t;
            case (op)
                OP_TOUCH:
                begin
                    if (flags.hit)
                    begin
                        if (WAY_W'(i) == pway)
                            na = '0;
                        else if (v && a < page)
                            na = a + AGE_W'(1);
                    end
                end
                OP_INVAL:
                begin
                    if (flags.hit)
                    begin
                        if (WAY_W'(i) == hit_way)
                        begin
                            nv = 1'b0;
                            na = '0;
                        end
                        else if (v && a > page)
                        begin
                            na = a - AGE_W'(1);
                        end
                    end
                end
                OP_FILL:
                begin
                    if (!flags.hit && flags.free_found)
                    begin
                        if (WAY_W'(i) == free_way)
                        begin
                            nv = 1'b1;
                            nt = tag;
                            na = '0;
                        end
                        else if (v)
                        begin
                            na = a + AGE_W'(1);
                        end
                    end
                    else
                    begin
                        // refresh on hit, or evict-and-replace the LRU way
                        if (WAY_W'(i) == pway)
                        begin
                            na = '0;
                            if (!flags.hit)
                                nt = tag;
                        end
                        else if (v && a < page)
                        begin
                            na = a + AGE_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            new_row[i*ENT_W +: ENT_W] = {nv, na, nt};
        end
    end

endmodule

// ----- hdl/set_assoc_lru_tag_store.sv -----
`timescale 1ns / 1ps
// Top level: set-associative tag store with true LRU replacement.
// Result strobe (done) is registered from the update state; an accepted beat passes lookup, then update.
// One item in flight at a time: the row read, compare, write-back sequence runs on the
//   single set memory, and busy stays high until it is through.
// Reset: asynchronous, active low. After reset a clearing pass writes every set row
//   (busy high) before the first item is taken. Results cannot be stalled.
module set_assoc_lru_tag_store #(
    parameter int SETS      = salru_pkg::SETS_DEF,
    parameter int WAYS      = salru_pkg::WAYS_DEF,
    parameter int ADDR_BITS = salru_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [ADDR_BITS-1:0] block_address,
    output logic                 done,
    output logic                 hit,
    output logic                 victim_valid,
    output logic [ADDR_BITS-1:0] victim_address,
    output logic                 not_found
);

    import salru_pkg::*;

    // Address split: low SET_BITS pick the set, the rest is the tag.
    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int SET_W    = (SETS > 1) ? SET_BITS : 1;
    localparam int TAG_W    = ADDR_BITS - SET_BITS;
    localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W    = AGE_W;
    // Per way a row holds {valid, age, tag}; a whole set is one memory word.
    localparam int ENT_W    = 1 + AGE_W + TAG_W;
    localparam int ROW_W    = WAYS * ENT_W;

    salru_state_t      state_reg, state_next;
    logic [SET_W-1:0]  clear_cnt_reg, clear_cnt_next;

    // Captured request
    salru_op_t         op_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  set_reg;

    // Compare results held from the lookup cycle into the update cycle
    salru_match_t      flags_reg;
    logic [WAY_W-1:0]  hit_way_reg, free_way_reg, victim_way_reg;

    // Result beat
    logic                 done_reg;
    logic                 res_hit_reg, res_vv_reg, res_nf_reg;
    logic [ADDR_BITS-1:0] res_va_reg;

    logic              accept;
    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]  rd_row;
    logic [SET_W-1:0]  req_set;

    salru_match_t      flags;
    logic [WAY_W-1:0]  hit_way, free_way, victim_way;
    logic [ROW_W-1:0]  new_row;
    logic [TAG_W-1:0]  victim_tag;

    logic                 upd_nf, upd_vv;
    logic [ADDR_BITS-1:0] upd_va;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign req_set = SET_W'(block_address & ADDR_BITS'(SETS - 1));

    // The row is read at the accept edge; data is valid in the lookup cycle and
    // stays put until the next accept, so the update cycle reuses it.
    salru_mem #(
        .DEPTH  (SETS),
        .WIDTH  (ROW_W),
        .ADDR_W (SET_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (req_set),
        .rd_data (rd_row)
    );

    salru_match #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .AGE_W (AGE_W),
        .WAY_W (WAY_W)
    ) u_match (
        .row        (rd_row),
        .tag        (tag_reg),
        .flags      (flags),
        .hit_way    (hit_way),
        .free_way   (free_way),
        .victim_way (victim_way)
    );

    salru_row_update #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .AGE_W (AGE_W),
        .WAY_W (WAY_W)
    ) u_update (
        .row        (rd_row),
        .tag        (tag_reg),
        .op         (op_reg),
        .flags      (flags_reg),
        .hit_way    (hit_way_reg),
        .free_way   (free_way_reg),
        .victim_way (victim_way_reg),
        .new_row    (new_row),
        .victim_tag (victim_tag)
    );

    // Control: clearing pass, then idle / lookup / update per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = set_reg;
        mem_wdata      = new_row;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Empty rows: all ways invalid, ages zero.
                mem_we         = 1'b1;
                mem_waddr      = clear_cnt_reg;
                mem_wdata      = '0;
                clear_cnt_next = clear_cnt_reg + SET_W'(1);
                if (clear_cnt_reg == SET_W'(SETS - 1))
                begin
                    state_next     = ST_IDLE;
                    clear_cnt_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Write back every time; lookup, and touch or invalidate misses, write the row unchanged.
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Request capture at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= salru_op_t'(op);
            tag_reg <= TAG_W'(block_address >> SET_BITS);
            set_reg <= req_set;
        end
    end

    // Compare results registered to split compare from row update
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
        begin
            flags_reg      <= flags;
            hit_way_reg    <= hit_way;
            free_way_reg   <= free_way;
            victim_way_reg <= victim_way;
        end
    end

    // Result fields; zero wherever they do not apply.
    always_comb
    begin
        upd_nf = ((op_reg == OP_TOUCH) || (op_reg == OP_INVAL)) && !flags_reg.hit;
        upd_vv = (op_reg == OP_FILL) && !flags_reg.hit && !flags_reg.free_found;
        upd_va = '0;
        if (upd_vv)
            upd_va = (ADDR_BITS'(victim_tag) << SET_BITS) | ADDR_BITS'(set_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == ST_UPDATE);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            res_hit_reg <= flags_reg.hit;
            res_vv_reg  <= upd_vv;
            res_va_reg  <= upd_va;
            res_nf_reg  <= upd_nf;
        end
    end

    assign done           = done_reg;
    assign hit            = res_hit_reg;
    assign victim_valid   = res_vv_reg;
    assign victim_address = res_va_reg;
    assign not_found      = res_nf_reg;

endmodule

// ----- hdl/salru_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the tag store, bound to the top level.
module salru_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic victim_valid,
    input logic not_found
);

    // Each accepted beat yields its result beat after the compare and write-back.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("no result beat for accepted item");

    // One item in flight: the block stays busy through lookup and update.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy)
        else $error("block took a new item while one was in flight");

    // Result beats never come back to back.
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    // An eviction only happens on a miss and never with not_found.
    a_victim_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && victim_valid) |-> (!hit && !not_found))
        else $error("victim reported on a hit or with not_found");

    a_not_found_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && not_found) |-> !hit)
        else $error("not_found reported on a hit");

endmodule

bind set_assoc_lru_tag_store salru_checker u_salru_checker (.*);

// ----- sim/salru_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard for the LRU tag store: shadow tag array, queue of awaited results, field compare.
module salru_scoreboard #(
    parameter int SETS      = salru_pkg::SETS_DEF,
    parameter int WAYS      = salru_pkg::WAYS_DEF,
    parameter int ADDR_BITS = salru_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [1:0]           op,
    input  logic [ADDR_BITS-1:0] block_address,
    input  logic                 done,
    input  logic                 hit,
    input  logic                 victim_valid,
    input  logic [ADDR_BITS-1:0] victim_address,
    input  logic                 not_found,
    output int                   mismatches,
    output int                   pending
);
    import salru_pkg::*;

    localparam int SB    = $clog2(SETS);
    localparam int TAG_W = ADDR_BITS - SB;

    typedef struct packed {
        logic                 hit;
        logic                 victim_valid;
        logic [ADDR_BITS-1:0] victim_address;
        logic                 not_found;
    } tag_result_t;

    logic             line_valid [SETS][WAYS];
    logic [TAG_W-1:0] line_tag   [SETS][WAYS];
    int               line_age   [SETS][WAYS];

    tag_result_t awaited_results[$];
    tag_result_t oldest;
    tag_result_t predicted;
    int          fail_count = 0;
    int          outstanding = 0;

    assign mismatches = fail_count;
    assign pending    = outstanding;

    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("[%0t] tag store mismatch: %s", $time, what);
    endtask

    // Way w becomes most recent; valid ways younger than it age by one.
    task automatic make_youngest(input int s, input int w);
        int a;
        a = line_age[s][w];
        for (int i = 0; i < WAYS; i++)
            if (i != w && line_valid[s][i] && line_age[s][i] < a)
                line_age[s][i]++;
        line_age[s][w] = 0;
    endtask

    task automatic predict_tag_access(input salru_op_t code, input logic [ADDR_BITS-1:0] addr,
                                      output tag_result_t r);
        int               s;
        int               hit_way;
        int               free_way;
        int               lru_way;
        int               a;
        logic [TAG_W-1:0] t;
        s = int'(addr % SETS);
        t = TAG_W'(addr >> SB);
        r = '0;
        hit_way = -1;
        for (int i = 0; i < WAYS; i++)
            if (hit_way < 0 && line_valid[s][i] && line_tag[s][i] == t)
                hit_way = i;
        r.hit = (hit_way >= 0);
        case (code)
            OP_TOUCH:
            begin
                if (r.hit)
                    make_youngest(s, hit_way);
                else
                    r.not_found = 1'b1;
            end
            OP_INVAL:
            begin
                if (r.hit)
                begin
                    a = line_age[s][hit_way];
                    for (int i = 0; i < WAYS; i++)
                        if (line_valid[s][i] && line_age[s][i] > a)
                            line_age[s][i]--;
                    line_valid[s][hit_way] = 1'b0;
                    line_age[s][hit_way]   = 0;
                end
                else
                begin
                    r.not_found = 1'b1;
                end
            end
            OP_FILL:
            begin
                if (r.hit)
                begin
                    make_youngest(s, hit_way);
                end
                else
                begin
                    free_way = -1;
                    for (int i = 0; i < WAYS; i++)
                        if (free_way < 0 && !line_valid[s][i])
                            free_way = i;
                    if (free_way >= 0)
                    begin
                        for (int i = 0; i < WAYS; i++)
                            if (line_valid[s][i])
                                line_age[s][i]++;
                        line_valid[s][free_way] = 1'b1;
                        line_tag[s][free_way]   = t;
                        line_age[s][free_way]   = 0;
                    end
                    else
                    begin
                        // set full: oldest way goes, lowest way wins a tie
                        lru_way = 0;
                        for (int i = 1; i < WAYS; i++)
                            if (line_age[s][i] > line_age[s][lru_way])
                                lru_way = i;
                        r.victim_valid   = 1'b1;
                        r.victim_address = (ADDR_BITS'(line_tag[s][lru_way]) << SB)
                                           | ADDR_BITS'(s);
                        line_tag[s][lru_way] = t;
                        make_youngest(s, lru_way);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
                for (int w = 0; w < WAYS; w++)
                begin
                    line_valid[s][w] = 1'b0;
                    line_age[s][w]   = 0;
                end
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // a result always belongs to a beat taken at an earlier edge
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    flag_mismatch("result strobe with no access outstanding");
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (hit !== oldest.hit)
                        flag_mismatch($sformatf("hit got %b want %b", hit, oldest.hit));
                    if (victim_valid !== oldest.victim_valid)
                        flag_mismatch($sformatf("victim_valid got %b want %b",
                                                victim_valid, oldest.victim_valid));
                    if (victim_address !== oldest.victim_address)
                        flag_mismatch($sformatf("victim_address got %h want %h",
                                                victim_address, oldest.victim_address));
                    if (not_found !== oldest.not_found)
                        flag_mismatch($sformatf("not_found got %b want %b",
                                                not_found, oldest.not_found));
                end
            end
            if (start && !busy)
            begin
                predict_tag_access(salru_op_t'(op), block_address, predicted);
                awaited_results.push_back(predicted);
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, access stimulus and verdict for the LRU tag store.
module tb_top;
    import salru_pkg::*;

    localparam int SETS       = SETS_DEF;
    localparam int WAYS       = WAYS_DEF;
    localparam int ADDR_BITS  = ADDR_BITS_DEF;
    localparam int SB         = $clog2(SETS);
    localparam int TAG_W      = ADDR_BITS - SB;
    localparam int NUM_RANDOM = 600;
    localparam int CALM_TAIL  = 100;     // last stretch runs back to back
    localparam int POOL_SIZE  = 12;      // more tags than ways, so hot sets overflow
    localparam int LIMIT      = 100000;  // watchdog bound, far above the slowest legal run

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    salru_op_t            op;
    logic [ADDR_BITS-1:0] block_address;
    logic                 busy;
    logic                 done;
    logic                 hit;
    logic                 victim_valid;
    logic [ADDR_BITS-1:0] victim_address;
    logic                 not_found;

    int mismatches;
    int pending;
    int cycles = 0;
    int gappy  = 1;

    logic [TAG_W-1:0] tag_pool [POOL_SIZE];
    int               hot_set  [4];

    // 12 ns clock
    always #6 clk = ~clk;

    // hard stop in case the handshake hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("set_assoc_lru_tag_store verification failed");
            $finish;
        end
    end

    set_assoc_lru_tag_store #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .block_address  (block_address),
        .done           (done),
        .hit            (hit),
        .victim_valid   (victim_valid),
        .victim_address (victim_address),
        .not_found      (not_found)
    );

    salru_scoreboard #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .block_address  (block_address),
        .done           (done),
        .hit            (hit),
        .victim_valid   (victim_valid),
        .victim_address (victim_address),
        .not_found      (not_found),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // tag in the upper bits, set index in the low SB bits
    function automatic logic [ADDR_BITS-1:0] mk_addr(input logic [TAG_W-1:0] t, input int s);
        return (ADDR_BITS'(t) << SB) | ADDR_BITS'(s);
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TAG_W-1:0];
    endfunction

    // Present one beat and hold it until taken. Called right after a rising edge;
    // busy read here is the value the edge just sampled.
    task automatic issue(input salru_op_t code, input logic [ADDR_BITS-1:0] addr);
        start         <= 1'b1;
        op            <= code;
        block_address <= addr;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Idle bursts with start low, in stretches that switch on and off; none when calm.
    task automatic idle_after_beat(input bit calm);
        int n;
        if ($urandom_range(0, 24) == 0)
            gappy = !gappy;
        if (!calm && gappy && $urandom_range(0, 99) < 35) begin
            n = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial begin
        int               sel;
        int               s;
        salru_op_t        code;
        logic [TAG_W-1:0] t;

        start         = 1'b0;
        op            = OP_LOOKUP;
        block_address = '0;
        rst_n         = 1'b0;

        // tag pool keeps the all-zero and all-one tags so every address bit toggles
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            tag_pool[i] = rand_tag();
        hot_set[0] = 0;
        hot_set[1] = SETS - 1;
        hot_set[2] = $urandom_range(0, SETS - 1);
        hot_set[3] = $urandom_range(0, SETS - 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // first beat waits out the clearing pass on busy

        // --- directed part ---
        issue(OP_LOOKUP, '0);                   // miss on an empty store
        idle_after_beat(1'b0);
        issue(OP_TOUCH, '0);                    // touch of absent block
        idle_after_beat(1'b0);
        issue(OP_INVAL, '0);                    // invalidate of absent block
        idle_after_beat(1'b0);
        issue(OP_FILL, '0);                     // lowest address, free way
        idle_after_beat(1'b0);
        issue(OP_FILL, '1);                     // highest address, top set
        idle_after_beat(1'b0);
        issue(OP_LOOKUP, '1);
        idle_after_beat(1'b0);
        issue(OP_FILL, '0);                     // refill of resident block only refreshes
        idle_after_beat(1'b0);
        for (int k = 1; k < WAYS; k++) begin    // fill set 0 to the brim
            issue(OP_FILL, mk_addr(TAG_W'(k), 0));
            idle_after_beat(1'b0);
        end
        issue(OP_TOUCH, mk_addr('0, 0));        // tag 1 is now least recent
        idle_after_beat(1'b0);
        issue(OP_FILL, mk_addr(TAG_W'(WAYS), 0));      // evicts tag 1
        idle_after_beat(1'b0);
        issue(OP_INVAL, mk_addr(TAG_W'(3), 0));        // frees a middle way
        idle_after_beat(1'b0);
        issue(OP_LOOKUP, mk_addr(TAG_W'(3), 0));
        idle_after_beat(1'b0);
        issue(OP_FILL, mk_addr(TAG_W'(WAYS + 1), 0));  // lands in the freed way
        idle_after_beat(1'b0);
        issue(OP_FILL, mk_addr(TAG_W'(WAYS + 2), 0));  // full again: evicts
        idle_after_beat(1'b0);
        issue(OP_TOUCH, '1);
        idle_after_beat(1'b0);
        issue(OP_INVAL, '1);
        idle_after_beat(1'b0);
        issue(OP_INVAL, '1);                    // second time: absent
        idle_after_beat(1'b0);
        issue(OP_LOOKUP, mk_addr('1, 0));
        idle_after_beat(1'b0);

        // --- random part: mostly hot sets and pooled tags so fills evict ---
        for (int n = 0; n < NUM_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                code = OP_FILL;
            else if (sel < 55)
                code = OP_LOOKUP;
            else if (sel < 78)
                code = OP_TOUCH;
            else
                code = OP_INVAL;
            if ($urandom_range(0, 99) < 80)
                s = hot_set[$urandom_range(0, 3)];
            else
                s = $urandom_range(0, SETS - 1);
            if ($urandom_range(0, 99) < 75)
                t = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                t = rand_tag();
            issue(code, mk_addr(t, s));
            idle_after_beat(n >= NUM_RANDOM - CALM_TAIL);
        end
        start <= 1'b0;

        // drain, then wait on for any stray strobe
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("set_assoc_lru_tag_store verification clean");
        else
            $display("set_assoc_lru_tag_store verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/salru_pkg.sv
hdl/salru_mem.sv
hdl/salru_match.sv
hdl/salru_row_update.sv
hdl/set_assoc_lru_tag_store.sv
hdl/salru_checker.sv
sim/salru_scoreboard.sv
sim/tb_top.sv
